>>> design/mvp_pkg.sv
// ----------------------------------------------------------------------------
// mvp_pkg
// Shared types and codes of the matrix-vector product block: opcode and
// register index codes, the work item passed from front to back, and the
// result item.
// ----------------------------------------------------------------------------
package mvp_pkg;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_MATRIX = 1'b1;

   localparam logic REG_ROW_COUNT    = 1'b0;
   localparam logic REG_COLUMN_COUNT = 1'b1;

   localparam int unsigned VALUE_W = 16;
   localparam int unsigned PROD_W  = 32;
   localparam int unsigned DOT_W   = 48;
   localparam int unsigned INDEX_W = 10;
   localparam int unsigned COUNT_W = 11;

   typedef struct packed {
      logic signed [VALUE_W-1:0] matrix_value;
      logic signed [VALUE_W-1:0] vector_value;
      logic                      row_end;
      logic [INDEX_W-1:0]        row_index;
      logic                      last_row;
   } mvp_work_type;

   typedef struct packed {
      logic signed [DOT_W-1:0] dot_result;
      logic [INDEX_W-1:0]      row_index;
      logic                    last_row;
   } mvp_result_type;

endpackage

>>> design/mvp_queue.sv
// ----------------------------------------------------------------------------
// mvp_queue
// Small synchronous FIFO with push/full and pop/empty sides. Depth is a power
// of two; the head entry is shown on pop_data while empty is low.
// ----------------------------------------------------------------------------
module mvp_queue #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == (AW+1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? AW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? AW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = (AW+1)'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = (AW+1)'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> design/mvp_front.sv
// ----------------------------------------------------------------------------
// mvp_front
// Accepts items, holds the count registers and the vector store, tracks the
// column and row positions, and hands each matrix element with its vector
// element and row flags to the work queue.
// ----------------------------------------------------------------------------
module mvp_front #(
   parameter int unsigned MAX_COLUMNS = 1024,
   parameter int unsigned MAX_ROWS    = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic                                opcode,
   input  logic signed [mvp_pkg::VALUE_W-1:0]  element_value,
   input  logic [mvp_pkg::INDEX_W-1:0]         vector_index,
   input  logic                                csr_valid,
   input  logic                                csr_index,
   input  logic [mvp_pkg::COUNT_W-1:0]         csr_write_data,
   output logic                                work_push,
   output mvp_pkg::mvp_work_type               work_data,
   input  logic                                work_full
);

   localparam int unsigned CW = $clog2(MAX_COLUMNS);
   localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

   logic [mvp_pkg::VALUE_W-1:0] store_mem [MAX_COLUMNS];
   logic [mvp_pkg::VALUE_W-1:0] read_ff;

   logic [CW-1:0] col_last_ff, col_last_in;
   logic [RW-1:0] row_last_ff, row_last_in;
   logic [CW-1:0] col_pos_ff, col_pos_in;
   logic [RW-1:0] row_pos_ff, row_pos_in;

   logic                               stage_valid_ff, stage_valid_in;
   logic signed [mvp_pkg::VALUE_W-1:0] stage_value_ff;
   logic                               stage_end_ff;
   logic [mvp_pkg::INDEX_W-1:0]        stage_row_ff;
   logic                               stage_last_ff;

   logic accept, load_write, matrix_accept, row_end, matrix_end;

   assign full          = stage_valid_ff && work_full;
   assign accept        = push && !full;
   assign matrix_accept = accept && (opcode == mvp_pkg::OP_MATRIX);
   assign load_write    = accept && (opcode == mvp_pkg::OP_LOAD)
                          && (32'(vector_index) < MAX_COLUMNS);
   assign row_end       = (col_pos_ff >= col_last_ff);
   assign matrix_end    = (row_pos_ff >= row_last_ff);

   assign work_push              = stage_valid_ff;
   assign work_data.matrix_value = stage_value_ff;
   assign work_data.vector_value = $signed(read_ff);
   assign work_data.row_end      = stage_end_ff;
   assign work_data.row_index    = stage_row_ff;
   assign work_data.last_row     = stage_last_ff;

   // clamp counts at write time and keep last positions
   always_comb begin
      col_last_in = col_last_ff;
      row_last_in = row_last_ff;
      if (csr_valid) begin
         unique case (csr_index)
            mvp_pkg::REG_ROW_COUNT: begin
               if (csr_write_data == '0) begin
                  row_last_in = '0;
               end else if (32'(csr_write_data) > MAX_ROWS) begin
                  row_last_in = RW'(MAX_ROWS - 1);
               end else begin
                  row_last_in = RW'(csr_write_data - 1'b1);
               end
            end
            mvp_pkg::REG_COLUMN_COUNT: begin
               if (csr_write_data == '0) begin
                  col_last_in = '0;
               end else if (32'(csr_write_data) > MAX_COLUMNS) begin
                  col_last_in = CW'(MAX_COLUMNS - 1);
               end else begin
                  col_last_in = CW'(csr_write_data - 1'b1);
               end
            end
            default: begin
               col_last_in = col_last_ff;
            end
         endcase
      end
   end

   always_comb begin
      col_pos_in = col_pos_ff;
      row_pos_in = row_pos_ff;
      if (matrix_accept) begin
         if (row_end) begin
            col_pos_in = '0;
            row_pos_in = matrix_end ? '0 : RW'(row_pos_ff + 1'b1);
         end else begin
            col_pos_in = CW'(col_pos_ff + 1'b1);
         end
      end
   end

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (matrix_accept) begin
         stage_valid_in = 1'b1;
      end else if (stage_valid_ff && !work_full) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_last_ff    <= '0;
         row_last_ff    <= '0;
         col_pos_ff     <= '0;
         row_pos_ff     <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         col_last_ff    <= col_last_in;
         row_last_ff    <= row_last_in;
         col_pos_ff     <= col_pos_in;
         row_pos_ff     <= row_pos_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (matrix_accept) begin
         stage_value_ff <= element_value;
         stage_end_ff   <= row_end;
         stage_row_ff   <= mvp_pkg::INDEX_W'(row_pos_ff);
         stage_last_ff  <= row_end && matrix_end;
      end
   end

   always_ff @(posedge clock) begin
      if (load_write) begin
         store_mem[CW'(vector_index)] <= element_value;
      end
      if (matrix_accept) begin
         read_ff <= store_mem[col_pos_ff];
      end
   end

endmodule

>>> design/mvp_back.sv
// ----------------------------------------------------------------------------
// mvp_back
// Multiply stage and row accumulator. Takes work items from the work queue,
// forms the exact Q16.16 product, adds it into the row sum and pushes the
// finished row into the result queue.
// ----------------------------------------------------------------------------
module mvp_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   work_empty,
   input  mvp_pkg::mvp_work_type  work_data,
   output logic                   work_pop,
   output logic                   result_push,
   output mvp_pkg::mvp_result_type result_data,
   input  logic                   result_full
);

   logic                              mul_valid_ff, mul_valid_in;
   logic signed [mvp_pkg::PROD_W-1:0] mul_prod_ff;
   logic signed [mvp_pkg::PROD_W-1:0] mul_prod_in;
   logic                              mul_end_ff;
   logic [mvp_pkg::INDEX_W-1:0]       mul_row_ff;
   logic                              mul_last_ff;

   logic [mvp_pkg::DOT_W-1:0] acc_ff, acc_in;
   logic [mvp_pkg::DOT_W-1:0] sum;
   logic                      acc_fire, mul_ready;

   assign acc_fire  = mul_valid_ff && (!mul_end_ff || !result_full);
   assign mul_ready = !mul_valid_ff || acc_fire;
   assign work_pop  = !work_empty && mul_ready;

   assign mul_prod_in = work_data.matrix_value * work_data.vector_value;
   assign sum = acc_ff + {{(mvp_pkg::DOT_W - mvp_pkg::PROD_W){mul_prod_ff[mvp_pkg::PROD_W-1]}},
                          mul_prod_ff};

   assign result_push             = acc_fire && mul_end_ff;
   assign result_data.dot_result  = $signed(sum);
   assign result_data.row_index   = mul_row_ff;
   assign result_data.last_row    = mul_last_ff;

   always_comb begin
      mul_valid_in = mul_valid_ff;
      if (work_pop) begin
         mul_valid_in = 1'b1;
      end else if (acc_fire) begin
         mul_valid_in = 1'b0;
      end
      acc_in = acc_ff;
      if (acc_fire) begin
         acc_in = mul_end_ff ? '0 : sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         acc_ff       <= '0;
      end else begin
         mul_valid_ff <= mul_valid_in;
         acc_ff       <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (work_pop) begin
         mul_prod_ff <= mul_prod_in;
         mul_end_ff  <= work_data.row_end;
         mul_row_ff  <= work_data.row_index;
         mul_last_ff <= work_data.last_row;
      end
   end

endmodule

>>> design/matrix_vector_product.sv
// ----------------------------------------------------------------------------
// matrix_vector_product
// Streaming matrix-vector product: signed Q8.8 vector loads and row-major
// matrix elements in, one exact Q32.16 dot product out per matrix row.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle while full is low, load or matrix element;
// the rate is set by the single-port vector store, which serves one write or
// one read per cycle, and by the one multiplier in the back end. A row result
// passes from its last matrix element through the store read, work queue,
// multiply and result queue to the result ports, with the accumulate feeding
// the result queue directly. Load a vector element before any matrix element
// that uses it; loads take effect for every matrix element transferred after
// them. Write the count registers only while the block is idle; csr_ready is
// always high.
module matrix_vector_product #(
   parameter int unsigned MAX_COLUMNS = 1024,
   parameter int unsigned MAX_ROWS    = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic                                req_opcode,
   input  logic signed [mvp_pkg::VALUE_W-1:0]  req_element_value,
   input  logic [mvp_pkg::INDEX_W-1:0]         req_vector_index,
   output logic                                empty,
   input  logic                                pop,
   output logic signed [mvp_pkg::DOT_W-1:0]    rsp_dot_result,
   output logic [mvp_pkg::INDEX_W-1:0]         rsp_row_index,
   output logic                                rsp_last_row,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic                                csr_index,
   input  logic [mvp_pkg::COUNT_W-1:0]         csr_write_data
);

   localparam int unsigned WORK_W   = $bits(mvp_pkg::mvp_work_type);
   localparam int unsigned RESULT_W = $bits(mvp_pkg::mvp_result_type);

   mvp_pkg::mvp_work_type   work_in, work_out;
   mvp_pkg::mvp_result_type result_in, result_out;
   logic work_push, work_full, work_pop, work_empty;
   logic result_push, result_full;

   assign csr_ready      = 1'b1;
   assign rsp_dot_result = result_out.dot_result;
   assign rsp_row_index  = result_out.row_index;
   assign rsp_last_row   = result_out.last_row;

   mvp_front #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .opcode         (req_opcode),
      .element_value  (req_element_value),
      .vector_index   (req_vector_index),
      .csr_valid      (csr_valid),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .work_push      (work_push),
      .work_data      (work_in),
      .work_full      (work_full)
   );

   mvp_queue #(
      .WIDTH (WORK_W),
      .DEPTH (4)
   ) u_work_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (work_push),
      .push_data (work_in),
      .full      (work_full),
      .pop       (work_pop),
      .pop_data  (work_out),
      .empty     (work_empty)
   );

   mvp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .work_empty  (work_empty),
      .work_data   (work_out),
      .work_pop    (work_pop),
      .result_push (result_push),
      .result_data (result_in),
      .result_full (result_full)
   );

   mvp_queue #(
      .WIDTH (RESULT_W),
      .DEPTH (2)
   ) u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (result_push),
      .push_data (result_in),
      .full      (result_full),
      .pop       (pop),
      .pop_data  (result_out),
      .empty     (empty)
   );

endmodule

>>> tb/sv/tb_matrix_vector_product.sv
// ----------------------------------------------------------------------------
// tb_matrix_vector_product
// Self-checking bench for the streaming matrix-vector product. Vector loads
// and row-major matrix elements are streamed through the push/full side
// with random gaps, while results are drained through empty/pop with random
// stalls. An in-bench multiply-accumulate model tracks the vector store, the
// row sum and the row/column positions, and every result transfer is
// compared field by field against the oldest predicted row. Count registers
// are rewritten between phases, including zero, oversized and largest
// counts, and counts that change in the middle of a row.
// ----------------------------------------------------------------------------
module tb_matrix_vector_product;

   localparam int unsigned MAX_COLUMNS       = 1024;
   localparam int unsigned MAX_ROWS          = 1024;
   localparam int unsigned RANDOM_ITEMS      = 780;
   localparam int unsigned DIRECTED_ELEMENTS = 24;
   localparam int unsigned WATCHDOG_LIMIT    = 2000;
   localparam int unsigned SETTLE_CYCLES     = 8;

   typedef struct {
      logic                               opcode;
      logic signed [mvp_pkg::VALUE_W-1:0] value;
      logic [mvp_pkg::INDEX_W-1:0]        index;
   } mvp_item_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               push = 1'b0;
   logic                               full;
   logic                               req_opcode = mvp_pkg::OP_LOAD;
   logic signed [mvp_pkg::VALUE_W-1:0] req_element_value = '0;
   logic [mvp_pkg::INDEX_W-1:0]        req_vector_index = '0;
   logic                               empty;
   logic                               pop = 1'b0;
   logic signed [mvp_pkg::DOT_W-1:0]   rsp_dot_result;
   logic [mvp_pkg::INDEX_W-1:0]        rsp_row_index;
   logic                               rsp_last_row;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic                               csr_index = mvp_pkg::REG_ROW_COUNT;
   logic [mvp_pkg::COUNT_W-1:0]        csr_write_data = '0;

   // stimulus side
   mvp_item_type   pending_items[$];
   bit             gen_written[MAX_COLUMNS];
   int unsigned    gen_col = 0;
   int unsigned    gen_cols = 1;
   int unsigned    random_items = 0;

   // prediction side
   logic signed [mvp_pkg::VALUE_W-1:0] vec_copy[MAX_COLUMNS];
   logic [mvp_pkg::DOT_W-1:0]          dot_sum = '0;
   int unsigned                        col_at = 0;
   int unsigned                        row_at = 0;
   logic [mvp_pkg::COUNT_W-1:0]        rows_reg = 11'd1;
   logic [mvp_pkg::COUNT_W-1:0]        cols_reg = 11'd1;
   mvp_pkg::mvp_result_type            expected_dots[$];

   // handshake bookkeeping
   bit          req_taken = 1'b0;
   bit          rsp_taken = 1'b0;
   bit          req_burst = 1'b0;
   bit          rsp_burst = 1'b0;
   int unsigned req_gap = 0;
   int unsigned rsp_stall = 0;
   int unsigned idle_cycles = 0;
   int unsigned error_count = 0;
   bit          progress;

   matrix_vector_product dut (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_opcode     (req_opcode),
      .req_element_value (req_element_value),
      .req_vector_index  (req_vector_index),
      .empty          (empty),
      .pop            (pop),
      .rsp_dot_result (rsp_dot_result),
      .rsp_row_index  (rsp_row_index),
      .rsp_last_row   (rsp_last_row),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   always #5 clock = ~clock;

   function automatic int unsigned count_in_use(logic [mvp_pkg::COUNT_W-1:0] v,
                                                int unsigned limit);
      if (v == 0) begin
         return 1;
      end
      return (v > limit) ? limit : int'(v);
   endfunction

   function automatic void accumulate_item(logic op,
                                           logic signed [mvp_pkg::VALUE_W-1:0] value,
                                           logic [mvp_pkg::INDEX_W-1:0] idx);
      logic signed [mvp_pkg::DOT_W-1:0] product;
      logic [mvp_pkg::DOT_W-1:0]        sum;
      mvp_pkg::mvp_result_type          row_dot;
      bit                               final_row;
      if (op == mvp_pkg::OP_LOAD) begin
         vec_copy[idx] = value;
         return;
      end
      product = value * vec_copy[col_at];
      sum = dot_sum + product;
      if (col_at + 1 < count_in_use(cols_reg, MAX_COLUMNS)) begin
         dot_sum = sum;
         col_at++;
         return;
      end
      final_row = (row_at + 1 >= count_in_use(rows_reg, MAX_ROWS));
      row_dot.dot_result = sum;
      row_dot.row_index = row_at[mvp_pkg::INDEX_W-1:0];
      row_dot.last_row = final_row;
      expected_dots.push_back(row_dot);
      dot_sum = '0;
      col_at = 0;
      row_at = final_row ? 0 : row_at + 1;
   endfunction

   // sample at the rising edge: check results, predict on input transfers
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         progress = 1'b0;
         if (pop && !empty) begin
            progress = 1'b1;
            rsp_taken = 1'b1;
            if (expected_dots.size() == 0) begin
               $display("%0t unexpected result: dot_result %0d row_index %0d last_row %0b",
                        $time, rsp_dot_result, rsp_row_index, rsp_last_row);
               error_count++;
            end else begin
               if (rsp_dot_result !== expected_dots[0].dot_result) begin
                  $display("%0t dot_result expected %0d actual %0d", $time,
                           expected_dots[0].dot_result, rsp_dot_result);
                  error_count++;
               end
               if (rsp_row_index !== expected_dots[0].row_index) begin
                  $display("%0t row_index expected %0d actual %0d", $time,
                           expected_dots[0].row_index, rsp_row_index);
                  error_count++;
               end
               if (rsp_last_row !== expected_dots[0].last_row) begin
                  $display("%0t last_row expected %0b actual %0b", $time,
                           expected_dots[0].last_row, rsp_last_row);
                  error_count++;
               end
               void'(expected_dots.pop_front());
            end
         end
         if (push && !full) begin
            progress = 1'b1;
            req_taken = 1'b1;
            accumulate_item(req_opcode, req_element_value, req_vector_index);
         end
         if (csr_valid && csr_ready) begin
            progress = 1'b1;
            if (csr_index == mvp_pkg::REG_ROW_COUNT) begin
               rows_reg = csr_write_data;
            end else begin
               cols_reg = csr_write_data;
            end
         end
         idle_cycles = progress ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no transfer for %0d cycles", $time, idle_cycles);
            $display("FAIL matrix_vector_product");
            $finish;
         end
      end
   end

   // input driver: hold until transfer, then wait a drawn gap
   always @(negedge clock) begin
      mvp_item_type item;
      if (reset) begin
         push <= 1'b0;
      end else if (!push || req_taken) begin
         req_taken = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
            push <= 1'b0;
         end else if (pending_items.size() > 0) begin
            item = pending_items.pop_front();
            req_opcode <= item.opcode;
            req_element_value <= item.value;
            req_vector_index <= item.index;
            push <= 1'b1;
            if ($urandom_range(0, 31) == 0) begin
               req_burst = !req_burst;
            end
            req_gap = req_burst ? 0 : $urandom_range(0, 16);
         end else begin
            push <= 1'b0;
         end
      end
   end

   // result side: stall a drawn number of cycles after each transfer
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (rsp_taken) begin
            rsp_taken = 1'b0;
            if ($urandom_range(0, 31) == 0) begin
               rsp_burst = !rsp_burst;
            end
            rsp_stall = rsp_burst ? 0 : $urandom_range(0, 16);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   function automatic logic signed [mvp_pkg::VALUE_W-1:0] draw_element();
      case ($urandom_range(0, 7))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'sh0000;
         3: return -16'sd1;
         default: return mvp_pkg::VALUE_W'($urandom);
      endcase
   endfunction

   task automatic queue_load(logic [mvp_pkg::INDEX_W-1:0] idx,
                             logic signed [mvp_pkg::VALUE_W-1:0] value);
      mvp_item_type item;
      item.opcode = mvp_pkg::OP_LOAD;
      item.value = value;
      item.index = idx;
      pending_items.push_back(item);
      gen_written[idx] = 1'b1;
   endtask

   // load the current column first if it was never written
   task automatic queue_matrix(logic signed [mvp_pkg::VALUE_W-1:0] value);
      mvp_item_type item;
      if (!gen_written[gen_col]) begin
         queue_load(gen_col[mvp_pkg::INDEX_W-1:0], draw_element());
         random_items++;
      end
      item.opcode = mvp_pkg::OP_MATRIX;
      item.value = value;
      item.index = mvp_pkg::INDEX_W'($urandom);
      pending_items.push_back(item);
      gen_col = (gen_col + 1 < gen_cols) ? gen_col + 1 : 0;
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_items.size() != 0 || push || expected_dots.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_count(logic idx, logic [mvp_pkg::COUNT_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      do @(posedge clock);
      while (!(csr_valid && csr_ready));
      if (idx == mvp_pkg::REG_COLUMN_COUNT) begin
         gen_cols = count_in_use(data, MAX_COLUMNS);
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_matrix(logic [mvp_pkg::COUNT_W-1:0] rows,
                             logic [mvp_pkg::COUNT_W-1:0] cols,
                             int unsigned elements);
      write_count(mvp_pkg::REG_ROW_COUNT, rows);
      write_count(mvp_pkg::REG_COLUMN_COUNT, cols);
      repeat (elements) queue_matrix(draw_element());
      wait_idle();
   endtask

   initial begin
      int unsigned phase_items;
      logic [mvp_pkg::COUNT_W-1:0] rows;
      logic [mvp_pkg::COUNT_W-1:0] cols;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset counts: one row, one column
      queue_load(10'd0, 16'sh8000);
      queue_matrix(16'sh8000);
      queue_matrix(16'sh7FFF);
      queue_load(10'd0, 16'sh7FFF);
      queue_matrix(16'sh7FFF);
      queue_matrix(16'sh8000);
      queue_load(10'd1023, 16'sh7FFF);
      queue_load(10'd0, -16'sd1);
      queue_matrix(16'sh0001);
      wait_idle();

      // two rows of three, then shrink the column count in the middle of a row
      write_count(mvp_pkg::REG_ROW_COUNT, 11'd2);
      write_count(mvp_pkg::REG_COLUMN_COUNT, 11'd3);
      repeat (6) queue_matrix(draw_element());
      repeat (2) queue_matrix(draw_element());
      wait_idle();
      write_count(mvp_pkg::REG_COLUMN_COUNT, 11'd1);
      queue_matrix(16'sh7FFF);
      queue_matrix(16'sh8000);
      wait_idle();

      // largest, zero and oversized counts
      run_matrix(11'd1024, 11'd1, DIRECTED_ELEMENTS);
      run_matrix(11'd2047, 11'd0, DIRECTED_ELEMENTS);
      run_matrix(11'd1, 11'd1024, DIRECTED_ELEMENTS);
      run_matrix(11'd0, 11'd2047, DIRECTED_ELEMENTS);

      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0: rows = 11'd0;
            1: rows = mvp_pkg::COUNT_W'($urandom_range(9, 40));
            default: rows = mvp_pkg::COUNT_W'($urandom_range(1, 6));
         endcase
         case ($urandom_range(0, 9))
            0: cols = 11'd0;
            1: cols = mvp_pkg::COUNT_W'($urandom_range(9, 64));
            default: cols = mvp_pkg::COUNT_W'($urandom_range(1, 8));
         endcase
         write_count(mvp_pkg::REG_ROW_COUNT, rows);
         write_count(mvp_pkg::REG_COLUMN_COUNT, cols);
         phase_items = $urandom_range(10, 60);
         repeat (phase_items) begin
            case ($urandom_range(0, 9))
               0: queue_load(mvp_pkg::INDEX_W'($urandom), draw_element());
               1: queue_load(mvp_pkg::INDEX_W'($urandom_range(0, gen_cols - 1)),
                             draw_element());
               default: queue_matrix(draw_element());
            endcase
            random_items++;
         end
         wait_idle();
      end

      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_dots.size() == 0) begin
         $display("PASS matrix_vector_product");
      end else begin
         $display("FAIL matrix_vector_product");
      end
      $finish;
   end

endmodule
